// File: hdl/dbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbs_pkg: shared types and constants of the detection box squarer
// Field widths, register map, configuration bundle, controller commands.
// ----------------------------------------------------------------------------
package dbs_pkg;

  localparam int EDGE_W     = 27;
  localparam int CONF_W     = 16;
  localparam int SCALE_W    = 29;
  localparam int FACTOR_W   = 12;
  localparam int DIM_W      = 14;
  localparam int POS_W      = 13;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 29;

  localparam int FRAC_W  = 32;
  localparam int PROD_W  = EDGE_W + SCALE_W + 1;
  localparam int HI_W    = PROD_W - FRAC_W;
  localparam int COORD_W = 28;
  localparam int BOUND_W = COORD_W + 1;
  localparam int GROW_W  = COORD_W + 6;
  localparam int LEN_W   = COORD_W + FACTOR_W + 2;
  localparam int LEN_SH  = 9;
  localparam int HALF_W  = LEN_W - LEN_SH;

  localparam logic [DIM_W-1:0]    DIM_MAX    = 14'd8192;
  localparam logic [DIM_W-1:0]    DIM_MIN    = 14'd1;
  localparam logic [FACTOR_W:0]   UNIT_GAIN  = 13'd256;
  localparam logic [GROW_W-1:0]   SIDE_MUL   = 34'd20;
  localparam logic [GROW_W-1:0]   LIMIT_MUL  = 34'd17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECORD_FORMAT        = 3'd0,
    REG_MAX_RECORDS          = 3'd1,
    REG_SCORE_FLOOR          = 3'd2,
    REG_ENLARGE_FACTOR       = 3'd3,
    REG_IMAGE_WIDTH          = 3'd4,
    REG_IMAGE_HEIGHT         = 3'd5,
    REG_X_SCALE              = 3'd6,
    REG_Y_SCALE              = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                  record_format;
    logic [COUNT_W-1:0]    max_records;
    logic [CONF_W-1:0]     score_floor;
    logic [FACTOR_W-1:0]   enlarge_factor;
    logic [DIM_W-1:0]      image_width;
    logic [DIM_W-1:0]      image_height;
    logic [SCALE_W-1:0]    x_scale;
    logic [SCALE_W-1:0]    y_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    record_format:        1'b1,
    max_records:          11'd200,
    score_floor:          16'd32768,
    enlarge_factor:       12'd307,
    image_width:          14'd640,
    image_height:         14'd480,
    x_scale:              29'd41943040,
    y_scale:              29'd31457280
  };

  typedef struct packed {
    logic load_in;
    logic step_mul;
    logic step_edge;
    logic step_cent;
    logic step_enl;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic score_pass;
    logic box_keep;
  } status_t;

endpackage
`default_nettype wire

// File: hdl/dbs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbs_if: record and box channels
// Valid/ready channels carrying one detector record or one square box.
// ----------------------------------------------------------------------------
interface dbs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 negative_image;
  logic [dbs_pkg::CONF_W-1:0]           confidence;
  logic signed [dbs_pkg::EDGE_W-1:0]    left_edge;
  logic signed [dbs_pkg::EDGE_W-1:0]    top_edge;
  logic signed [dbs_pkg::EDGE_W-1:0]    right_edge;
  logic signed [dbs_pkg::EDGE_W-1:0]    bottom_edge;
  logic                                 frame_last;

  modport source (
    output valid, negative_image, confidence, left_edge, top_edge, right_edge,
           bottom_edge, frame_last,
    input  ready
  );
  modport sink (
    input  valid, negative_image, confidence, left_edge, top_edge, right_edge,
           bottom_edge, frame_last,
    output ready
  );
endinterface

interface dbs_out_if;
  logic                          valid;
  logic                          ready;
  logic [dbs_pkg::POS_W-1:0]     box_x;
  logic [dbs_pkg::POS_W-1:0]     box_y;
  logic [dbs_pkg::DIM_W-1:0]     box_side;
  logic [dbs_pkg::CONF_W-1:0]    box_score;

  modport source (
    output valid, box_x, box_y, box_side, box_score,
    input  ready
  );
  modport sink (
    input  valid, box_x, box_y, box_side, box_score,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/detection_box_squarer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// detection_box_squarer_unit: square face boxes from detector records
// Filters detector records and emits square, clamped boxes in image pixels.
// ----------------------------------------------------------------------------
// Records enter on in_if, one per transfer; a kept record yields one box on
// out_if, a dropped one yields nothing. Registers are written on the cfg_
// port (cfg_we, cfg_index, cfg_wdata); the user writes them only while no
// record is in flight, as the block itself does not enforce this. A kept
// record passes from its transfer to its box landing in the output register
// through these steps: the transfer, each edge times its scale, then
// pixel edges, center and larger side, the enlarge multiply, and the clamp.
// The next record is taken once the clamp is done, one record at a time.
// Boxes sit in an output register: a new record is accepted while a box
// waits, and if the receiver stalls with a box still held, the clamp step
// holds until the box transfers. Synchronous reset returns the registers to
// their defaults, clears the record count and list end flag, and drops any
// pending box.
// ----------------------------------------------------------------------------
module detection_box_squarer_unit #(
  parameter int RECORD_LIMIT = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  dbs_in_if.sink                                 in_if,
  dbs_out_if.source                              out_if,
  input  wire logic                              cfg_we,
  input  wire logic [dbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dbs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  dbs_pkg::cfg_t    cfg_r, cfg_nxt;
  dbs_pkg::cmd_t    cmd;
  dbs_pkg::status_t status;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (dbs_pkg::cfg_reg_t'(cfg_index))
        dbs_pkg::REG_RECORD_FORMAT:
          cfg_nxt.record_format = cfg_wdata[0];
        dbs_pkg::REG_MAX_RECORDS:
          cfg_nxt.max_records = cfg_wdata[dbs_pkg::COUNT_W-1:0];
        dbs_pkg::REG_SCORE_FLOOR:
          cfg_nxt.score_floor = cfg_wdata[dbs_pkg::CONF_W-1:0];
        dbs_pkg::REG_ENLARGE_FACTOR:
          cfg_nxt.enlarge_factor = cfg_wdata[dbs_pkg::FACTOR_W-1:0];
        dbs_pkg::REG_IMAGE_WIDTH:
          cfg_nxt.image_width = cfg_wdata[dbs_pkg::DIM_W-1:0];
        dbs_pkg::REG_IMAGE_HEIGHT:
          cfg_nxt.image_height = cfg_wdata[dbs_pkg::DIM_W-1:0];
        dbs_pkg::REG_X_SCALE:
          cfg_nxt.x_scale = cfg_wdata[dbs_pkg::SCALE_W-1:0];
        dbs_pkg::REG_Y_SCALE:
          cfg_nxt.y_scale = cfg_wdata[dbs_pkg::SCALE_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= dbs_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dbs_ctrl #(
    .RECORD_LIMIT (RECORD_LIMIT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_if.valid),
    .in_neg    (in_if.negative_image),
    .in_last   (in_if.frame_last),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .status    (status),
    .cmd       (cmd)
  );

  dbs_datapath u_datapath (
    .clk       (clk),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .status    (status),
    .in_conf   (in_if.confidence),
    .in_left   (in_if.left_edge),
    .in_top    (in_if.top_edge),
    .in_right  (in_if.right_edge),
    .in_bottom (in_if.bottom_edge),
    .box_x     (out_if.box_x),
    .box_y     (out_if.box_y),
    .box_side  (out_if.box_side),
    .box_score (out_if.box_score)
  );

endmodule
`default_nettype wire

// File: hdl/dbs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbs_ctrl: record sequencer
// Record counting, list end tracking, step sequencing and output valid.
// ----------------------------------------------------------------------------
module dbs_ctrl #(
  parameter int RECORD_LIMIT = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dbs_pkg::cfg_t    cfg,
  input  wire logic             in_valid,
  input  wire logic             in_neg,
  input  wire logic             in_last,
  output logic                  in_ready,
  input  wire logic             out_ready,
  output logic                  out_valid,
  input  wire dbs_pkg::status_t status,
  output dbs_pkg::cmd_t         cmd
);

  localparam int COUNT_MAX = (1 << dbs_pkg::COUNT_W) - 1;
  localparam int LIMIT_CAP = (RECORD_LIMIT > COUNT_MAX) ? COUNT_MAX : RECORD_LIMIT;
  localparam logic [dbs_pkg::COUNT_W-1:0] LIMIT_C = dbs_pkg::COUNT_W'(LIMIT_CAP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_EDGE,
    S_CENT,
    S_ENL,
    S_CLAMP
  } state_t;

  state_t                       state_r, state_nxt;
  logic [dbs_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic                         ended_r, ended_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [dbs_pkg::COUNT_W-1:0]  eff_limit;
  logic                         examine;

  assign eff_limit = (cfg.max_records < LIMIT_C) ? cfg.max_records : LIMIT_C;
  assign examine   = !ended_r && (count_r < eff_limit);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ended_nxt     = ended_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) begin
          if (examine) begin
            count_nxt = dbs_pkg::COUNT_W'(count_r + 1'b1);
            if (cfg.record_format && in_neg) begin
              ended_nxt = 1'b1;
            end else if (status.score_pass) begin
              state_nxt = S_MUL;
            end
          end
          if (in_last) begin
            count_nxt = '0;
            ended_nxt = 1'b0;
          end
        end
      end
      S_MUL: begin
        cmd.step_mul = 1'b1;
        state_nxt    = S_EDGE;
      end
      S_EDGE: begin
        cmd.step_edge = 1'b1;
        state_nxt     = S_CENT;
      end
      S_CENT: begin
        cmd.step_cent = 1'b1;
        state_nxt     = S_ENL;
      end
      S_ENL: begin
        cmd.step_enl = 1'b1;
        state_nxt    = S_CLAMP;
      end
      S_CLAMP: begin
        if (!status.box_keep) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/dbs_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbs_datapath: box arithmetic
// Scaling products, pixel edges, center, enlargement, clamp, output register.
// ----------------------------------------------------------------------------
module dbs_datapath (
  input  wire logic                                clk,
  input  wire dbs_pkg::cfg_t                       cfg,
  input  wire dbs_pkg::cmd_t                       cmd,
  output dbs_pkg::status_t                         status,
  input  wire logic [dbs_pkg::CONF_W-1:0]          in_conf,
  input  wire logic signed [dbs_pkg::EDGE_W-1:0]   in_left,
  input  wire logic signed [dbs_pkg::EDGE_W-1:0]   in_top,
  input  wire logic signed [dbs_pkg::EDGE_W-1:0]   in_right,
  input  wire logic signed [dbs_pkg::EDGE_W-1:0]   in_bottom,
  output logic [dbs_pkg::POS_W-1:0]                box_x,
  output logic [dbs_pkg::POS_W-1:0]                box_y,
  output logic [dbs_pkg::DIM_W-1:0]                box_side,
  output logic [dbs_pkg::CONF_W-1:0]               box_score
);

  localparam int CW = dbs_pkg::COORD_W;
  localparam int PW = dbs_pkg::PROD_W;
  localparam int FW = dbs_pkg::FRAC_W;
  localparam int HW = dbs_pkg::HI_W;
  localparam int BW = dbs_pkg::BOUND_W;
  localparam int GW = dbs_pkg::GROW_W;
  localparam int LW = dbs_pkg::LEN_W;
  localparam int SW = dbs_pkg::SCALE_W;
  localparam int DW = dbs_pkg::DIM_W;
  localparam int QW = dbs_pkg::HALF_W;
  localparam int LS = dbs_pkg::LEN_SH;

  logic [dbs_pkg::CONF_W-1:0]         conf_r;
  logic signed [dbs_pkg::EDGE_W-1:0]  left_r, top_r, right_r, bottom_r;
  logic signed [PW-1:0]               pl_r, pt_r, pr_r, pb_r;
  logic signed [CW-1:0]               x_r, y_r, w_r, h_r;
  logic signed [CW-1:0]               cx_r, cy_r, mside_r;
  logic                               grow_r;
  logic signed [LW-1:0]               len_r;
  logic signed [BW-1:0]               bound_r;
  logic [dbs_pkg::POS_W-1:0]          box_x_r, box_y_r;
  logic [DW-1:0]                      box_side_r;
  logic [dbs_pkg::CONF_W-1:0]         box_score_r;

  logic [DW-1:0]         iw_sat, ih_sat;
  logic signed [SW:0]    xs_s, ys_s;
  logic signed [CW-1:0]  xf, yf, rf, bf, x_nxt, y_nxt, dx, dy, w_nxt, h_nxt;
  logic signed [CW-1:0]  w_sum, h_sum, hw, hh_half, cx_nxt, cy_nxt, mside_nxt;
  logic signed [GW-1:0]  w_ext, h_ext, iw_g, ih_g, w20, h20, lim_w, lim_h;
  logic                  grow_nxt;
  logic signed [dbs_pkg::FACTOR_W:0] fac_s;
  logic signed [LW-1:0]  len_nxt;
  logic signed [BW-1:0]  iw_b, ih_b, cx_b, cy_b, rx, ry, bmin0, bmin1, bound_nxt;
  logic signed [QW-1:0]  hf, hq, bnd, half;
  logic                  keep;
  logic [CW-1:0]         half_c, bx, by;

  always_comb begin
    iw_sat = cfg.image_width;
    if (cfg.image_width == '0) begin
      iw_sat = dbs_pkg::DIM_MIN;
    end else if (cfg.image_width > dbs_pkg::DIM_MAX) begin
      iw_sat = dbs_pkg::DIM_MAX;
    end
    ih_sat = cfg.image_height;
    if (cfg.image_height == '0) begin
      ih_sat = dbs_pkg::DIM_MIN;
    end else if (cfg.image_height > dbs_pkg::DIM_MAX) begin
      ih_sat = dbs_pkg::DIM_MAX;
    end
  end

  assign status.score_pass = in_conf > cfg.score_floor;

  // Scaling products
  assign xs_s = {1'b0, cfg.x_scale};
  assign ys_s = {1'b0, cfg.y_scale};

  // Pixel edges, truncated toward zero
  always_comb begin
    xf    = {{(CW-HW){pl_r[PW-1]}}, pl_r[PW-1:FW]};
    yf    = {{(CW-HW){pt_r[PW-1]}}, pt_r[PW-1:FW]};
    rf    = {{(CW-HW){pr_r[PW-1]}}, pr_r[PW-1:FW]};
    bf    = {{(CW-HW){pb_r[PW-1]}}, pb_r[PW-1:FW]};
    x_nxt = xf + CW'(pl_r[PW-1] && (pl_r[FW-1:0] != '0));
    y_nxt = yf + CW'(pt_r[PW-1] && (pt_r[FW-1:0] != '0));
    dx    = rf - x_nxt;
    dy    = bf - y_nxt;
    w_nxt = dx + CW'(dx[CW-1] && (pr_r[FW-1:0] != '0));
    h_nxt = dy + CW'(dy[CW-1] && (pb_r[FW-1:0] != '0));
  end

  // Center, larger side, enlarge decision
  always_comb begin
    w_sum     = w_r + CW'(w_r[CW-1] & w_r[0]);
    h_sum     = h_r + CW'(h_r[CW-1] & h_r[0]);
    hw        = w_sum >>> 1;
    hh_half   = h_sum >>> 1;
    cx_nxt    = x_r + hw;
    cy_nxt    = y_r + hh_half;
    mside_nxt = (w_r > h_r) ? w_r : h_r;
    w_ext     = {{(GW-CW){w_r[CW-1]}}, w_r};
    h_ext     = {{(GW-CW){h_r[CW-1]}}, h_r};
    iw_g      = {{(GW-DW){1'b0}}, iw_sat};
    ih_g      = {{(GW-DW){1'b0}}, ih_sat};
    w20       = w_ext * $signed(dbs_pkg::SIDE_MUL);
    h20       = h_ext * $signed(dbs_pkg::SIDE_MUL);
    lim_w     = iw_g * $signed(dbs_pkg::LIMIT_MUL);
    lim_h     = ih_g * $signed(dbs_pkg::LIMIT_MUL);
    grow_nxt  = cfg.record_format || (w20 < lim_w) || (h20 < lim_h);
  end

  // Enlarged side and border distances
  always_comb begin
    fac_s     = grow_r ? {1'b0, cfg.enlarge_factor} : dbs_pkg::UNIT_GAIN;
    len_nxt   = mside_r * fac_s;
    iw_b      = {{(BW-DW){1'b0}}, iw_sat};
    ih_b      = {{(BW-DW){1'b0}}, ih_sat};
    cx_b      = {cx_r[CW-1], cx_r};
    cy_b      = {cy_r[CW-1], cy_r};
    rx        = iw_b - cx_b;
    ry        = ih_b - cy_b;
    bmin0     = (cx_b < cy_b) ? cx_b : cy_b;
    bmin1     = (rx < ry) ? rx : ry;
    bound_nxt = (bmin0 < bmin1) ? bmin0 : bmin1;
  end

  // Half side, clamp, square corner
  always_comb begin
    hf     = len_r[LW-1:LS];
    hq     = hf + QW'(len_r[LW-1] && (len_r[LS-1:0] != '0));
    bnd    = {{(QW-BW){bound_r[BW-1]}}, bound_r};
    half   = (hq < bnd) ? hq : bnd;
    keep   = !half[QW-1] && (half != '0);
    half_c = half[CW-1:0];
    bx     = cx_r - half_c;
    by     = cy_r - half_c;
  end

  assign status.box_keep = keep;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      conf_r   <= in_conf;
      left_r   <= in_left;
      top_r    <= in_top;
      right_r  <= in_right;
      bottom_r <= in_bottom;
    end
    if (cmd.step_mul) begin
      pl_r <= left_r * xs_s;
      pt_r <= top_r * ys_s;
      pr_r <= right_r * xs_s;
      pb_r <= bottom_r * ys_s;
    end
    if (cmd.step_edge) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      w_r <= w_nxt;
      h_r <= h_nxt;
    end
    if (cmd.step_cent) begin
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      mside_r <= mside_nxt;
      grow_r  <= grow_nxt;
    end
    if (cmd.step_enl) begin
      len_r   <= len_nxt;
      bound_r <= bound_nxt;
    end
    if (cmd.load_out) begin
      box_x_r     <= bx[dbs_pkg::POS_W-1:0];
      box_y_r     <= by[dbs_pkg::POS_W-1:0];
      box_side_r  <= {half[DW-2:0], 1'b0};
      box_score_r <= conf_r;
    end
  end

  assign box_x     = box_x_r;
  assign box_y     = box_y_r;
  assign box_side  = box_side_r;
  assign box_score = box_score_r;

endmodule
`default_nettype wire

// File: hdl/dbs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dbs_checker: port-level checks of the detection box squarer
// Reset, output hold and box geometry checks, bound to the top level.
// ----------------------------------------------------------------------------
module dbs_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic [dbs_pkg::POS_W-1:0]       box_x,
  input wire logic [dbs_pkg::POS_W-1:0]       box_y,
  input wire logic [dbs_pkg::DIM_W-1:0]       box_side,
  input wire logic [dbs_pkg::CONF_W-1:0]      box_score
);

  localparam int EXT_W = dbs_pkg::DIM_W + 1;

  logic [EXT_W-1:0] x_end, y_end;

  assign x_end = {2'b00, box_x} + {1'b0, box_side};
  assign y_end = {2'b00, box_y} + {1'b0, box_side};

  a_reset_drops_box: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("box valid right after reset");

  a_stall_holds_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(box_x) && $stable(box_y)
      && $stable(box_side) && $stable(box_score))
    else $error("stalled box changed or dropped");

  a_side_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (box_side[0] == 1'b0) && (box_side != '0))
    else $error("box side zero or odd");

  a_box_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (x_end <= EXT_W'(dbs_pkg::DIM_MAX))
      && (y_end <= EXT_W'(dbs_pkg::DIM_MAX)))
    else $error("box reaches past the frame limit");

endmodule

bind detection_box_squarer_unit dbs_checker u_dbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .box_x     (out_if.box_x),
  .box_y     (out_if.box_y),
  .box_side  (out_if.box_side),
  .box_score (out_if.box_score)
);
`default_nettype wire
